FILE: hw/rtl/c8i_pkg.sv
// ----------------------------------------------------------------------------
// c8i_pkg
// shared types, codes and helpers of the chip8 instruction core
// ----------------------------------------------------------------------------
package c8i_pkg;

    localparam int MEM_DEPTH_DEF     = 4096;
    localparam int STACK_DEPTH_DEF   = 16;
    localparam int SCREEN_WIDTH_DEF  = 64;
    localparam int SCREEN_HEIGHT_DEF = 32;

    localparam logic [11:0] START_RESET = 12'd512;
    localparam logic [15:0] SEED_RESET  = 16'd44257;
    localparam logic [15:0] LFSR_TAPS   = 16'hB400;

    // configuration register indexes
    localparam logic CFG_START = 1'b0;
    localparam logic CFG_SEED  = 1'b1;

    // item kinds
    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_EXEC  = 3'd1;
    localparam logic [2:0] OP_TICK  = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_ROW   = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNKNOWN   = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW = 3'd3;
    localparam logic [2:0] ST_WAITKEY   = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [11:0] address;
        logic [7:0]  write_data;
        logic [15:0] keys;
        logic [4:0]  row;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] pc;
        logic [15:0] instruction;
        logic [63:0] read_data;
        logic        collision;
        logic        beep;
    } rsp_t;

    // datapath operations issued by the controller
    localparam logic [4:0] DP_NOP      = 5'd0;
    localparam logic [4:0] DP_LATCH    = 5'd1;  // capture request, clear result
    localparam logic [4:0] DP_MEMWR    = 5'd2;  // load byte
    localparam logic [4:0] DP_MEMRD    = 5'd3;  // issue read at item address
    localparam logic [4:0] DP_RDDONE   = 5'd4;  // move read byte to result
    localparam logic [4:0] DP_ROWRD    = 5'd5;
    localparam logic [4:0] DP_TICK     = 5'd6;
    localparam logic [4:0] DP_FETCH_HI = 5'd7;  // issue read of pc
    localparam logic [4:0] DP_FETCH_LO = 5'd8;  // take hi, issue read of pc+1
    localparam logic [4:0] DP_FETCH_DN = 5'd9;  // take lo
    localparam logic [4:0] DP_DECODE   = 5'd10; // single-step execute
    localparam logic [4:0] DP_CLS      = 5'd11; // clear one screen row
    localparam logic [4:0] DP_IRD      = 5'd12; // issue read at I + count
    localparam logic [4:0] DP_DRAW     = 5'd13; // xor one sprite row
    localparam logic [4:0] DP_LDREG    = 5'd14; // V[count] <= read byte
    localparam logic [4:0] DP_STREG    = 5'd15; // mem[I+count] <= V[count]
    localparam logic [4:0] DP_BCD      = 5'd16; // mem[I+count] <= bcd digit
    localparam logic [4:0] DP_DRAWEND  = 5'd17;
    localparam logic [4:0] DP_COMMIT   = 5'd18; // pc <= next, status ok

    // multi-cycle jobs reported by decode
    localparam logic [2:0] JOB_NONE = 3'd0;
    localparam logic [2:0] JOB_CLS  = 3'd1;
    localparam logic [2:0] JOB_DRAW = 3'd2;
    localparam logic [2:0] JOB_BCD  = 3'd3;
    localparam logic [2:0] JOB_STR  = 3'd4;
    localparam logic [2:0] JOB_LDR  = 3'd5;

    typedef struct packed {
        logic [4:0] op;
        logic [4:0] count;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] job;    // valid the cycle after DP_DECODE
        logic [4:0] limit;  // last count of the job
    } dp_stat_t;

    // bcd digits of a byte: hundreds, tens, ones
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [7:0] h;
        logic [7:0] r;
        logic [7:0] t;
        begin
            h = (v >= 8'd200) ? 8'd2 : ((v >= 8'd100) ? 8'd1 : 8'd0);
            r = v - h * 8'd100;
            t = 8'(({8'd0, r} * 16'd205) >> 11);
            case (sel)
                2'd0:    bcd_digit = h;
                2'd1:    bcd_digit = t;
                default: bcd_digit = r - t * 8'd10;
            endcase
        end
    endfunction

endpackage

FILE: hw/rtl/c8i_stream_if.sv
// ----------------------------------------------------------------------------
// c8i_stream_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface c8i_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/c8i_ctrl.sv
// ----------------------------------------------------------------------------
// c8i_ctrl
// sequencer: accepts requests, steps the datapath, presents the result
// ----------------------------------------------------------------------------
module c8i_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         in_kind,
    output logic               out_valid,
    input  logic               out_ready,
    output c8i_pkg::dp_cmd_t   cmd,
    input  c8i_pkg::dp_stat_t  stat
);
    import c8i_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_RDW   = 4'd2;
    localparam logic [3:0] S_FLO   = 4'd3;
    localparam logic [3:0] S_FDN   = 4'd4;
    localparam logic [3:0] S_DEC   = 4'd5;
    localparam logic [3:0] S_JOB   = 4'd6;
    localparam logic [3:0] S_LOOP  = 4'd7;
    localparam logic [3:0] S_WAIT  = 4'd8;
    localparam logic [3:0] S_USE   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [2:0] kind_reg, kind_next;
    logic [2:0] job_reg, job_next;
    logic [4:0] lim_reg, lim_next;
    logic [4:0] cnt_reg, cnt_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= OP_LOAD;
            job_reg   <= JOB_NONE;
            lim_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            job_reg   <= job_next;
            lim_reg   <= lim_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        job_next   = job_reg;
        lim_next   = lim_reg;
        cnt_next   = cnt_reg;
        cmd.op     = DP_NOP;
        cmd.count  = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_LATCH;
                    kind_next  = in_kind;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (kind_reg)
                    OP_LOAD: begin cmd.op = DP_MEMWR; state_next = S_OUT; end
                    OP_TICK: begin cmd.op = DP_TICK;  state_next = S_OUT; end
                    OP_ROW:  begin cmd.op = DP_ROWRD; state_next = S_OUT; end
                    OP_READ: begin cmd.op = DP_MEMRD; state_next = S_RDW; end
                    OP_EXEC: begin cmd.op = DP_FETCH_HI; state_next = S_FLO; end
                    default: state_next = S_OUT;
                endcase
            end
            S_RDW:   begin cmd.op = DP_RDDONE;   state_next = S_OUT; end
            S_FLO:   begin cmd.op = DP_FETCH_LO; state_next = S_FDN; end
            S_FDN:   begin cmd.op = DP_FETCH_DN; state_next = S_DEC; end
            S_DEC:   begin cmd.op = DP_DECODE;   state_next = S_JOB; end
            S_JOB:
            begin
                job_next   = stat.job;
                lim_next   = stat.limit;
                cnt_next   = '0;
                state_next = (stat.job == JOB_NONE) ? S_OUT : S_LOOP;
            end
            S_LOOP:
            begin
                case (job_reg)
                    JOB_CLS:  cmd.op = DP_CLS;
                    JOB_BCD:  cmd.op = DP_BCD;
                    JOB_STR:  cmd.op = DP_STREG;
                    default:  cmd.op = DP_IRD;
                endcase
                if (job_reg == JOB_DRAW || job_reg == JOB_LDR)
                    state_next = S_WAIT;
                else if (cnt_reg == lim_reg)
                    state_next = S_FIN;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            // keep the read address on the byte so the read data holds
            S_WAIT:  begin cmd.op = DP_IRD; state_next = S_USE; end
            S_USE:
            begin
                cmd.op = (job_reg == JOB_DRAW) ? DP_DRAW : DP_LDREG;
                if (cnt_reg == lim_reg)
                    state_next = S_FIN;
                else
                begin
                    cnt_next   = cnt_reg + 5'd1;
                    state_next = S_LOOP;
                end
            end
            S_FIN:
            begin
                cmd.op     = (job_reg == JOB_DRAW) ? DP_DRAWEND : DP_COMMIT;
                state_next = S_OUT;
            end
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("request taken while busy");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> !out_valid)
        else $error("result repeated");
    a_loop_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOP) |-> (cnt_reg <= lim_reg))
        else $error("job counter past limit");
`endif

endmodule

FILE: hw/rtl/c8i_datapath.sv
// ----------------------------------------------------------------------------
// c8i_datapath
// architectural state, memory, frame buffer and the execute unit
// ----------------------------------------------------------------------------
module c8i_datapath #(
    parameter int MEM_DEPTH     = c8i_pkg::MEM_DEPTH_DEF,
    parameter int STACK_DEPTH   = c8i_pkg::STACK_DEPTH_DEF,
    parameter int SCREEN_WIDTH  = c8i_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = c8i_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  c8i_pkg::req_t      req,
    input  c8i_pkg::dp_cmd_t   cmd,
    output c8i_pkg::dp_stat_t  stat,
    output c8i_pkg::rsp_t      rsp,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);
    import c8i_pkg::*;

    localparam int MAW = $clog2(MEM_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int RW  = $clog2(SCREEN_HEIGHT);
    localparam int CW  = $clog2(SCREEN_WIDTH);

    logic [7:0]  mem [MEM_DEPTH];
    logic [11:0] stk [STACK_DEPTH];
    logic [SCREEN_WIDTH-1:0] fb_reg [SCREEN_HEIGHT];

    logic [7:0]  v_reg [16];
    logic [15:0] i_reg;
    logic [11:0] pc_reg;
    logic [SPW-1:0] sp_reg;
    logic [7:0]  dt_reg, st_reg;
    logic [15:0] lfsr_reg;

    req_t        rq_reg;
    rsp_t        rsp_reg;
    logic [7:0]  mrd_reg;
    logic [15:0] op_reg;
    logic [11:0] next_reg;
    logic [7:0]  ox_reg, oy_reg;
    logic        hit_reg;
    dp_stat_t    stat_reg;

    logic [2:0]  dec_status;
    logic [11:0] pc_next;
    logic [11:0] dec_next;
    logic        single;

    assign rsp  = rsp_reg;
    assign stat = stat_reg;

    // memory port: one write, one registered read
    logic           mwe;
    logic [MAW-1:0] mwa, mra;
    logic [7:0]     mwd;
    always_ff @(posedge clk)
    begin
        if (mwe) mem[mwa] <= mwd;
        mrd_reg <= mem[mra];
    end

    // decode fields
    logic [3:0]  ox, oy, on;
    logic [7:0]  kk, vx, vy;
    logic [11:0] nnn, pc2, pc4;
    logic [15:0] iaddr;
    logic [8:0]  sum9;
    assign ox   = op_reg[11:8];
    assign oy   = op_reg[7:4];
    assign on   = op_reg[3:0];
    assign kk   = op_reg[7:0];
    assign nnn  = op_reg[11:0];
    assign vx   = v_reg[ox];
    assign vy   = v_reg[oy];
    assign pc2  = pc_reg + 12'd2;
    assign pc4  = pc_reg + 12'd4;
    assign iaddr = i_reg + {11'd0, cmd.count};
    assign sum9 = {1'b0, vx} + {1'b0, vy};

    // alu flag goes to vf first; in subtract and shift an operand that names vf sees the new flag
    logic [7:0] alu_f, alu_ax, alu_ay;
    always_comb
    begin
        case (on)
            4'h5:    alu_f = {7'd0, vx > vy};
            4'h6:    alu_f = {7'd0, vx[0]};
            4'h7:    alu_f = {7'd0, vy > vx};
            4'hE:    alu_f = {7'd0, vx[7]};
            default: alu_f = {7'd0, sum9[8]};
        endcase
        alu_ax = (ox == 4'hF) ? alu_f : vx;
        alu_ay = (oy == 4'hF) ? alu_f : vy;
    end

    logic [15:0] lfsr_nx;
    assign lfsr_nx = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);

    logic keydn;
    assign keydn = (vx < 8'd16) && rq_reg.keys[vx[3:0]];

    // sprite row placed on the screen with wrap
    logic [SCREEN_WIDTH-1:0] smask;
    logic [RW-1:0]           drow;
    always_comb
    begin
        smask = '0;
        for (int c = 0; c < 8; c++)
            if (mrd_reg[7-c])
                smask[SCREEN_WIDTH-1-CW'(ox_reg + 8'(c))] = 1'b1;
        drow = RW'(oy_reg + {3'd0, cmd.count});
    end

    always_comb
    begin
        mwe = 1'b0;
        mwa = MAW'(rq_reg.address);
        mwd = rq_reg.write_data;
        mra = MAW'(rq_reg.address);
        case (cmd.op)
            DP_MEMWR:    mwe = 1'b1;
            DP_FETCH_HI: mra = MAW'(pc_reg);
            DP_FETCH_LO: mra = MAW'(pc2 - 12'd1);
            DP_IRD:      mra = MAW'(iaddr[11:0]);
            DP_STREG:
            begin
                mwe = 1'b1;
                mwa = MAW'(iaddr[11:0]);
                mwd = v_reg[cmd.count[3:0]];
            end
            DP_BCD:
            begin
                mwe = 1'b1;
                mwa = MAW'(iaddr[11:0]);
                mwd = bcd_digit(vx, cmd.count[1:0]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        stat_reg <= '{job: JOB_NONE, limit: '0};
        case (cmd.op)
            DP_LATCH:
            begin
                rq_reg  <= req;
                rsp_reg <= '0;
                op_reg  <= '0;
            end
            DP_RDDONE:   rsp_reg.read_data <= {56'd0, mrd_reg};
            DP_ROWRD:    rsp_reg.read_data <= 64'(fb_reg[RW'(rq_reg.row)]);
            DP_FETCH_LO: op_reg[15:8] <= mrd_reg;
            DP_FETCH_DN:
            begin
                op_reg[7:0] <= mrd_reg;
                rsp_reg.instruction <= {op_reg[15:8], mrd_reg};
            end
            DP_DECODE:
            begin
                next_reg <= pc2;
                ox_reg   <= vx;
                oy_reg   <= vy;
                hit_reg  <= 1'b0;
                case (op_reg[15:12])
                    4'h0:
                    begin
                        if (kk == 8'hE0 && ox == 4'd0)
                            stat_reg <= '{job: JOB_CLS, limit: 5'(SCREEN_HEIGHT - 1)};
                        else if (kk == 8'hEE && ox == 4'd0 && sp_reg != '0)
                            next_reg <= stk[SAW'(sp_reg - 1'b1)] + 12'd2;
                    end
                    4'h1: next_reg <= nnn;
                    4'h2: next_reg <= nnn;
                    4'h3: if (vx == kk) next_reg <= pc4;
                    4'h4: if (vx != kk) next_reg <= pc4;
                    4'h5: if (vx == vy) next_reg <= pc4;
                    4'h9: if (vx != vy) next_reg <= pc4;
                    4'hB: next_reg <= nnn + {4'd0, v_reg[0]};
                    4'hD: if (on != 4'd0)
                              stat_reg <= '{job: JOB_DRAW, limit: {1'b0, on} - 5'd1};
                    4'hE:
                    begin
                        if (kk == 8'h9E && keydn) next_reg <= pc4;
                        if (kk == 8'hA1 && !keydn) next_reg <= pc4;
                    end
                    4'hF:
                    begin
                        if (kk == 8'h33) stat_reg <= '{job: JOB_BCD, limit: 5'd2};
                        if (kk == 8'h55) stat_reg <= '{job: JOB_STR, limit: {1'b0, ox}};
                        if (kk == 8'h65) stat_reg <= '{job: JOB_LDR, limit: {1'b0, ox}};
                    end
                    default: ;
                endcase
            end
            DP_DRAW:     if ((fb_reg[drow] & smask) != '0) hit_reg <= 1'b1;
            DP_DRAWEND:  rsp_reg.collision <= hit_reg;
            default: ;
        endcase
        if (cmd.op == DP_DECODE || cmd.op == DP_COMMIT || cmd.op == DP_DRAWEND)
            rsp_reg.status <= dec_status;
        if (cmd.op == DP_DECODE && op_reg[15:12] == 4'h0 && kk == 8'hEE
            && ox == 4'd0 && sp_reg != '0)
            next_reg <= stk[SAW'(sp_reg - 1'b1)] + 12'd2;
        if (cmd.op == DP_DECODE && op_reg[15:12] == 4'hD && on == 4'd0)
            rsp_reg.collision <= 1'b0;
        rsp_reg.pc <= pc_next;
        if (cmd.op == DP_TICK)
            rsp_reg.beep <= (st_reg == 8'd2);
    end

    // status of the current instruction
    always_comb
    begin
        dec_status = ST_OK;
        case (op_reg[15:12])
            4'h0:
            begin
                if (ox != 4'd0 || (kk != 8'hE0 && kk != 8'hEE)) dec_status = ST_UNKNOWN;
                else if (kk == 8'hEE && sp_reg == '0)         dec_status = ST_UNDERFLOW;
            end
            4'h2: if (sp_reg >= SPW'(STACK_DEPTH)) dec_status = ST_OVERFLOW;
            4'h5, 4'h9: if (on != 4'd0) dec_status = ST_UNKNOWN;
            4'h8: if (!(on <= 4'h7 || on == 4'hE)) dec_status = ST_UNKNOWN;
            4'hE: if (kk != 8'h9E && kk != 8'hA1) dec_status = ST_UNKNOWN;
            4'hF:
            begin
                case (kk)
                    8'h07, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65: ;
                    8'h0A:   dec_status = ST_WAITKEY;
                    default: dec_status = ST_UNKNOWN;
                endcase
            end
            default: ;
        endcase
    end

    // pc after this cycle, reported in the result
    assign single = (cmd.op == DP_DECODE) && (dec_status == ST_OK)
                    && !(op_reg[15:12] == 4'h0 && kk == 8'hE0)
                    && !(op_reg[15:12] == 4'hD && on != 4'd0)
                    && !(op_reg[15:12] == 4'hF
                         && (kk == 8'h33 || kk == 8'h55 || kk == 8'h65));
    always_comb
    begin
        pc_next = pc_reg;
        if (cfg_we && cfg_index == CFG_START)
            pc_next = cfg_data[11:0];
        else if (cmd.op == DP_COMMIT || cmd.op == DP_DRAWEND)
            pc_next = next_reg;
        else if (single)
            pc_next = dec_next;
    end

    always_comb
    begin
        dec_next = pc2;
        case (op_reg[15:12])
            4'h0: if (kk == 8'hEE) dec_next = stk[SAW'(sp_reg - 1'b1)] + 12'd2;
            4'h1, 4'h2: dec_next = nnn;
            4'h3: if (vx == kk) dec_next = pc4;
            4'h4: if (vx != kk) dec_next = pc4;
            4'h5: if (vx == vy) dec_next = pc4;
            4'h9: if (vx != vy) dec_next = pc4;
            4'hB: dec_next = nnn + {4'd0, v_reg[0]};
            4'hE:
            begin
                if (kk == 8'h9E && keydn)  dec_next = pc4;
                if (kk == 8'hA1 && !keydn) dec_next = pc4;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
        if (single && op_reg[15:12] == 4'h2)
            stk[SAW'(sp_reg)] <= pc_reg;

    // frame buffer rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < SCREEN_HEIGHT; r++)
                fb_reg[r] <= '0;
        end
        else if (cmd.op == DP_CLS)
            fb_reg[RW'(cmd.count)] <= '0;
        else if (cmd.op == DP_DRAW)
            fb_reg[drow] <= fb_reg[drow] ^ smask;
    end

    // architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 16; k++)
                v_reg[k] <= '0;
            i_reg    <= '0;
            pc_reg   <= START_RESET;
            sp_reg   <= '0;
            dt_reg   <= '0;
            st_reg   <= '0;
            lfsr_reg <= SEED_RESET;
        end
        else
        begin
            pc_reg <= pc_next;
            if (cfg_we && cfg_index == CFG_SEED)
                lfsr_reg <= cfg_data;
            if (cmd.op == DP_TICK)
            begin
                if (dt_reg != '0) dt_reg <= dt_reg - 8'd1;
                if (st_reg != '0) st_reg <= st_reg - 8'd1;
            end
            if (cmd.op == DP_LDREG)
                v_reg[cmd.count[3:0]] <= mrd_reg;
            if (cmd.op == DP_DRAW || cmd.op == DP_DRAWEND)
                v_reg[15] <= {7'd0, hit_reg || (cmd.op == DP_DRAW
                              && (fb_reg[drow] & smask) != '0)};
            if (single)
            begin
                case (op_reg[15:12])
                    4'h0: if (kk == 8'hEE) sp_reg <= sp_reg - 1'b1;
                    4'h2: sp_reg <= sp_reg + 1'b1;
                    4'h6: v_reg[ox] <= kk;
                    4'h7: v_reg[ox] <= vx + kk;
                    4'h8:
                    begin
                        case (on)
                            4'h0: v_reg[ox] <= vy;
                            4'h1: v_reg[ox] <= vx | vy;
                            4'h2: v_reg[ox] <= vx & vy;
                            4'h3: v_reg[ox] <= vx ^ vy;
                            4'h4:
                            begin
                                v_reg[15] <= alu_f;
                                v_reg[ox] <= sum9[7:0];
                            end
                            4'h5:
                            begin
                                v_reg[15] <= alu_f;
                                v_reg[ox] <= alu_ax - alu_ay;
                            end
                            4'h6:
                            begin
                                v_reg[15] <= alu_f;
                                v_reg[ox] <= alu_ax >> 1;
                            end
                            4'h7:
                            begin
                                v_reg[15] <= alu_f;
                                v_reg[ox] <= alu_ay - alu_ax;
                            end
                            default:
                            begin
                                v_reg[15] <= alu_f;
                                v_reg[ox] <= alu_ax << 1;
                            end
                        endcase
                    end
                    4'hA: i_reg <= {4'd0, nnn};
                    4'hC:
                    begin
                        lfsr_reg  <= lfsr_nx;
                        v_reg[ox] <= lfsr_nx[7:0] & kk;
                    end
                    4'hF:
                    begin
                        case (kk)
                            8'h07:   v_reg[ox] <= dt_reg;
                            8'h15:   dt_reg <= vx;
                            8'h18:   st_reg <= vx;
                            8'h1E:   i_reg <= i_reg + {8'd0, vx};
                            default: i_reg <= {8'd0, vx} * 16'd5;
                        endcase
                    end
                    default: ;
                endcase
            end
            if (cmd.op == DP_DECODE && op_reg[15:12] == 4'hD && on == 4'd0
                && dec_status == ST_OK)
                v_reg[15] <= '0;
        end
    end

`ifndef ASSERT_OFF
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(STACK_DEPTH))
        else $error("stack pointer out of range");
    a_pc_hold_err: assert property (@(posedge clk) disable iff (!rst_n)
        (single == 1'b0 && cmd.op == DP_DECODE && !cfg_we) |=> $stable(pc_reg))
        else $error("pc moved on a faulting instruction");
    a_cls_row: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_CLS) |=> (fb_reg[RW'($past(cmd.count))] == '0))
        else $error("screen row not cleared");
`endif

endmodule

FILE: hw/rtl/chip8_instruction_core.sv
// ----------------------------------------------------------------------------
// chip8_instruction_core
// chip8 interpreter core with memory, registers, timers and frame buffer
// ----------------------------------------------------------------------------
// One request is handled at a time. An ordinary instruction is fetched by two
// reads of the single memory port, then decoded; a clear screen clears one row
// per cycle; a draw reads, holds and xors each sprite row in turn; Fx55 and
// Fx33 write their bytes one after another, Fx65 reads, holds and loads each
// byte in turn. The result waits in its register until taken. Memory, the
// return stack and the datapath's working registers have no reset; the
// sequencer, architectural registers and frame buffer reset at once.
module chip8_instruction_core #(
    parameter int MEM_DEPTH     = c8i_pkg::MEM_DEPTH_DEF,
    parameter int STACK_DEPTH   = c8i_pkg::STACK_DEPTH_DEF,
    parameter int SCREEN_WIDTH  = c8i_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = c8i_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    c8i_stream_if.sink   req,
    c8i_stream_if.source rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import c8i_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    rsp_t     rsp_data;
    req_t     req_data;

    assign req_data = req.data;
    assign rsp.data = rsp_data;

    // sequencer
    c8i_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_kind   (req_data.opcode),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // state and execute unit
    c8i_datapath #(
        .MEM_DEPTH     (MEM_DEPTH),
        .STACK_DEPTH   (STACK_DEPTH),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
